>>> src/fbfl_pkg.sv
package fbfl_pkg;

    // Field widths of the request, response and configuration beats
    localparam int INDEX_W   = 9;
    localparam int ADDR_W    = 33;
    localparam int STATUS_W  = 2;
    localparam int BASE_W    = 32;
    localparam int PAYLOAD_W = 16;
    localparam int STRIDE_W  = PAYLOAD_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES = 1'd1;

    localparam logic [BASE_W-1:0]    BASE_RESET    = 32'd0;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_RESET = 16'd64;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // request beat taken: latch it and read the pool RAM
        logic commit;   // decide, update the free list and load the response
    } fbfl_cmd_t;

endpackage

>>> src/fbfl_req_if.sv
interface fbfl_req_if
    import fbfl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, output opcode, output block_index, input ready);
    modport sink   (input valid, input opcode, input block_index, output ready);
endinterface

>>> src/fbfl_rsp_if.sv
interface fbfl_rsp_if
    import fbfl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [ADDR_W-1:0]   payload_address;

    modport source (output valid, output status, output granted_index,
                    output payload_address, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input payload_address, output ready);
endinterface

>>> src/fbfl_ram.sv
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fbfl_ctrl.sv
module fbfl_ctrl
    import fbfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output fbfl_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    // Response slot is free when empty or being drained this cycle
    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == S_EXEC) && slot_free;
    assign out_valid   = out_valid_reg;

    // Next state and response valid
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/fbfl_dp.sv
module fbfl_dp
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fbfl_cmd_t             cmd,
    input  logic                  opcode,
    input  logic [INDEX_W-1:0]    block_index,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [STATUS_W-1:0]   status,
    output logic [INDEX_W-1:0]    granted_index,
    output logic [ADDR_W-1:0]     payload_address
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
    localparam int AW     = $clog2(MAX_BLOCKS);
    localparam int CMP_W  = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam int PROD_W = STRIDE_W + AW;
    localparam int SUM_W  = ADDR_W + 1;
    localparam int WORD_W = IDX_W + 1;

    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(MAX_BLOCKS);
    localparam logic [CMP_W-1:0]    LAST_CMP = CMP_W'(MAX_BLOCKS);
    localparam logic [STRIDE_W-1:0] HDR_STR  = STRIDE_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]    HDR_SUM  = SUM_W'(HEADER_BYTES);

    // Configuration registers
    logic [BASE_W-1:0]    base_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    // Free list control state: head and high-water mark of allocated indices
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] hw_reg, hw_next;

    // Request latched at capture
    logic              op_reg;
    logic [IDX_W-1:0]  tgt_reg;
    logic              range_ok_reg;
    logic [PROD_W-1:0] prod_reg;

    // Response registers
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  granted_reg;
    logic [ADDR_W-1:0]   addr_reg;

    logic [CMP_W-1:0]    idx_ext;
    logic [IDX_W-1:0]    tgt_next;
    logic [IDX_W-1:0]    tgt_next_m1;
    logic                range_ok_next;
    logic [STRIDE_W-1:0] stride;
    logic [IDX_W-1:0]    tgt_m1;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_we;

    logic             fresh;
    logic             mark;
    logic [IDX_W-1:0] link;
    logic             ok;
    logic [CMP_W-1:0] granted_ext;
    logic [SUM_W-1:0] addr_sum;

    // Pool RAM: each word holds the used mark above the next link
    fbfl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tgt_m1[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (tgt_next_m1[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Target block at capture: head on allocate, given index on free
    assign idx_ext     = CMP_W'(block_index);
    assign tgt_next    = (opcode == OP_FREE) ? idx_ext[IDX_W-1:0] : head_reg;
    assign tgt_next_m1 = tgt_next - IDX_W'(1);
    assign stride      = STRIDE_W'(payload_reg) + HDR_STR;

    always_comb
    begin
        if (opcode == OP_FREE)
        begin
            range_ok_next = (idx_ext != '0) && (idx_ext <= LAST_CMP);
        end
        else
        begin
            range_ok_next = (head_reg != '0);
        end
    end

    // Entries above the high-water mark were never written: initial chain
    assign tgt_m1 = tgt_reg - IDX_W'(1);
    assign fresh  = (tgt_reg > hw_reg);
    assign mark   = fresh ? 1'b0 : ram_rdata[IDX_W];

    always_comb
    begin
        if (!fresh)
        begin
            link = ram_rdata[IDX_W-1:0];
        end
        else if (tgt_reg == LAST_IDX)
        begin
            link = '0;
        end
        else
        begin
            link = tgt_reg + IDX_W'(1);
        end
    end

    assign ok = range_ok_reg && ((op_reg == OP_ALLOC) ? !mark : mark);

    // Decision, list update and RAM write-back
    always_comb
    begin
        head_next = head_reg;
        hw_next   = hw_reg;
        ram_we    = 1'b0;
        ram_wdata = {1'b0, head_reg};
        if (cmd.commit && ok)
        begin
            ram_we = 1'b1;
            if (op_reg == OP_ALLOC)
            begin
                head_next = link;
                ram_wdata = {1'b1, link};
                if (fresh)
                begin
                    hw_next = tgt_reg;
                end
            end
            else
            begin
                head_next = tgt_reg;
                ram_wdata = {1'b0, head_reg};
            end
        end
    end

    assign granted_ext = CMP_W'(tgt_reg);
    assign addr_sum    = SUM_W'(base_reg) + SUM_W'(prod_reg) + HDR_SUM;

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= BASE_RESET;
            payload_reg <= PAYLOAD_RESET;
            head_reg    <= IDX_W'(1);
            hw_reg      <= '0;
        end
        else
        begin
            head_reg <= head_next;
            hw_reg   <= hw_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_ADDRESS:  base_reg    <= cfg_data;
                    CFG_PAYLOAD_BYTES: payload_reg <= cfg_data[PAYLOAD_W-1:0];
                    default:           base_reg    <= base_reg;
                endcase
            end
        end
    end

    // Request latch (stride product computed alongside the RAM read)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            tgt_reg      <= tgt_next;
            range_ok_reg <= range_ok_next;
            prod_reg     <= PROD_W'(stride) * PROD_W'(tgt_next_m1[AW-1:0]);
        end
    end

    // Response beat
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (ok && (op_reg == OP_ALLOC))
            begin
                status_reg  <= ST_DONE;
                granted_reg <= granted_ext[INDEX_W-1:0];
                addr_reg    <= addr_sum[ADDR_W-1:0];
            end
            else
            begin
                status_reg  <= ok ? ST_DONE
                                  : ((op_reg == OP_ALLOC) ? ST_EMPTY : ST_REFUSED);
                granted_reg <= '0;
                addr_reg    <= '0;
            end
        end
    end

    assign status          = status_reg;
    assign granted_index   = granted_reg;
    assign payload_address = addr_reg;

endmodule

>>> src/fixed_block_free_list_allocator.sv
// Channel   Dir  Beat fields
// req       in   opcode (0 allocate, 1 free), block_index[8:0]
// rsp       out  status[1:0], granted_index[8:0], payload_address[32:0]
// cfg       in   cfg_we, cfg_index (0 base_address, 1 payload_bytes), cfg_data[31:0]
//
// Each request is handled as a pool RAM read (link and used mark of the target
// block) at capture, then the decision, RAM write-back and response load at commit.
// A new request is taken once the previous one has committed.
// The free list comes up ready at reset; no clearing pass is needed.
// A stalled response holds the block in its commit cycle; a request may be
// taken while the previous response still waits.
module fixed_block_free_list_allocator
    import fbfl_pkg::*;
#(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fbfl_req_if.sink              req,
    fbfl_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fbfl_cmd_t cmd;
    logic      req_ready;
    logic      rsp_valid;

    fbfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req_ready),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    fbfl_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .opcode          (req.opcode),
        .block_index     (req.block_index),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .status          (rsp.status),
        .granted_index   (rsp.granted_index),
        .payload_address (rsp.payload_address)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule
